// ===== rtl/spmq_pkg.sv =====
package spmq_pkg;

  // Default sizing of the queue.
  localparam int NUM_LEVELS_DEF    = 5;
  localparam int FIFO_DEPTH_DEF    = 16;
  localparam int PAYLOAD_BYTES_DEF = 8;

  // Field widths of the words on both channels.
  localparam int TYPE_W    = 32;
  localparam int PRIO_W    = 3;
  localparam int PAYLOAD_W = 64;
  localparam int SIZE_W    = 4;
  localparam int STATUS_W  = 3;
  localparam int PEND_W    = 7;

  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 112;

  // Kind of an input word.
  localparam logic ACT_SEND = 1'b0;
  localparam logic ACT_RECV = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_PRIO  = 3'd1,
    ST_TOO_LARGE = 3'd2,
    ST_FULL      = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  // Commands from the top level to one priority level.
  typedef struct packed {
    logic push;
    logic pop;
  } lvl_ctrl_t;

  // Occupancy flags of one priority level.
  typedef struct packed {
    logic full;
    logic empty;
  } lvl_stat_t;

endpackage

// ===== rtl/spmq_cell.sv =====
module spmq_cell #(
  parameter int ENT_W = 96
) (
  input  logic             clk,
  input  logic             load,
  input  logic             shift,
  input  logic [ENT_W-1:0] new_data,
  input  logic [ENT_W-1:0] nbr_data,
  output logic [ENT_W-1:0] data
);

  logic [ENT_W-1:0] data_r;
  logic [ENT_W-1:0] data_nxt;

  // A cell either takes a new message, takes its upper neighbour's entry
  // when the head is popped, or holds.
  always_comb begin
    data_nxt = data_r;
    if (load) begin
      data_nxt = new_data;
    end else if (shift) begin
      data_nxt = nbr_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

// ===== rtl/spmq_level.sv =====
module spmq_level #(
  parameter int FIFO_DEPTH = spmq_pkg::FIFO_DEPTH_DEF,
  parameter int ENT_W      = 96,
  localparam int CNT_W     = $clog2(FIFO_DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  spmq_pkg::lvl_ctrl_t   ctrl,
  input  logic [ENT_W-1:0]      new_data,
  output logic [ENT_W-1:0]      head,
  output logic [CNT_W-1:0]      count,
  output spmq_pkg::lvl_stat_t   stat
);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [ENT_W-1:0] cell_data [FIFO_DEPTH];

  // Row of cells; slot 0 is the head and a pop moves every entry down one.
  for (genvar k = 0; k < FIFO_DEPTH; k++) begin : g_cell
    logic [ENT_W-1:0] nbr;
    if (k == FIFO_DEPTH - 1) begin : g_top
      assign nbr = cell_data[k];
    end else begin : g_mid
      assign nbr = cell_data[k+1];
    end
    spmq_cell #(
      .ENT_W (ENT_W)
    ) u_cell (
      .clk      (clk),
      .load     (ctrl.push && (count_r == CNT_W'(k))),
      .shift    (ctrl.pop),
      .new_data (new_data),
      .nbr_data (nbr),
      .data     (cell_data[k])
    );
  end

  // Fill count of this level.
  always_comb begin
    count_nxt = count_r;
    if (ctrl.push) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctrl.pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign head       = cell_data[0];
  assign count      = count_r;
  assign stat.full  = (count_r == CNT_W'(FIFO_DEPTH));
  assign stat.empty = (count_r == '0);

endmodule

// ===== rtl/strict_priority_message_queue.sv =====
// Strict-priority message queue with one FIFO per priority level.
// Input channel in_*: one word per request. in_tuser selects the request:
// send (0) appends a type word and a zero-padded payload to the FIFO of the
// requested level; receive (1) pops the head of the most urgent non-empty
// level, level 0 being the most urgent.
// Output channel out_*: exactly one word per request, carrying a status
// (ok, bad priority, payload too large, queue full, empty), the received
// message for a successful receive and the number of messages held in all
// levels after the request.
// An accepted request is held in the request register and its result word
// is then written to the output register. A new request is taken only after
// the held one has been executed and the request register is free again.
// The next request is taken while a result still waits in the output
// register; when the receiver stalls, the following request is held in the
// request register and in_tready stays low until the result is taken.
// Reset empties every level at once; stored entries keep no reset value.
module strict_priority_message_queue #(
  parameter int NUM_LEVELS    = spmq_pkg::NUM_LEVELS_DEF,
  parameter int FIFO_DEPTH    = spmq_pkg::FIFO_DEPTH_DEF,
  parameter int PAYLOAD_BYTES = spmq_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // msg_type[31:0], priority_req[34:32], payload[98:35], payload_size[102:99]
  input  logic [spmq_pkg::IN_TDATA_W-1:0]    in_tdata,
  // action[0]
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // status[2:0], out_type[34:3], out_payload[98:35], out_priority[101:99],
  // pending_total[108:102]
  output logic [spmq_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  localparam int PL_W  = 8 * PAYLOAD_BYTES;
  localparam int ENT_W = spmq_pkg::TYPE_W + PL_W;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int TOT_W = $clog2(NUM_LEVELS * FIFO_DEPTH + 1);

  // Request register.
  logic                                 busy_r;
  logic                                 busy_nxt;
  logic                                 act_r;
  logic [spmq_pkg::TYPE_W-1:0]          type_r;
  logic [spmq_pkg::PRIO_W-1:0]          prio_r;
  logic [spmq_pkg::PAYLOAD_W-1:0]       payload_r;
  logic [spmq_pkg::SIZE_W-1:0]          size_r;

  // Output register and running total.
  logic                                 out_valid_r;
  logic                                 out_valid_nxt;
  logic [spmq_pkg::OUT_TDATA_W-1:0]     out_data_r;
  logic [spmq_pkg::OUT_TDATA_W-1:0]     out_data_nxt;
  logic [TOT_W-1:0]                     total_r;
  logic [TOT_W-1:0]                     total_nxt;

  logic                                 in_fire;
  logic                                 exec;
  logic                                 prio_ok;
  logic                                 size_ok;
  logic                                 full_sel;
  logic                                 found;
  logic                                 push_ok;
  logic                                 pop_ok;
  spmq_pkg::status_t                    status;
  logic [spmq_pkg::PRIO_W-1:0]          rx_prio;
  logic [ENT_W-1:0]                     rx_head;
  logic [PL_W-1:0]                      padded;
  logic [ENT_W-1:0]                     new_entry;
  logic [TOT_W+spmq_pkg::PEND_W-1:0]    total_ext;
  logic [spmq_pkg::TYPE_W-1:0]          o_type;
  logic [spmq_pkg::PAYLOAD_W-1:0]       o_payload;
  logic [spmq_pkg::PRIO_W-1:0]          o_prio;
  logic [TOT_W-1:0]                     cnt_sum;

  spmq_pkg::lvl_ctrl_t                  ctrl [NUM_LEVELS];
  spmq_pkg::lvl_stat_t                  stat [NUM_LEVELS];
  logic [ENT_W-1:0]                     heads [NUM_LEVELS];
  logic [CNT_W-1:0]                     counts [NUM_LEVELS];

  assign in_tready = !busy_r;
  assign in_fire   = in_tvalid && in_tready;
  assign exec      = busy_r && (!out_valid_r || out_tready);

  // Capture the request.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      act_r     <= in_tuser;
      type_r    <= in_tdata[31:0];
      prio_r    <= in_tdata[34:32];
      payload_r <= in_tdata[98:35];
      size_r    <= in_tdata[102:99];
    end
  end

  // Zero the payload bytes at and above the given size.
  always_comb begin
    for (int b = 0; b < PAYLOAD_BYTES; b++) begin
      padded[8*b +: 8] = (size_r > spmq_pkg::SIZE_W'(b)) ? payload_r[8*b +: 8] : 8'h00;
    end
    new_entry = {padded, type_r};
  end

  // Request checks, level selection and the result word.
  always_comb begin
    prio_ok  = ({1'b0, prio_r} < (spmq_pkg::PRIO_W + 1)'(NUM_LEVELS));
    size_ok  = (size_r <= spmq_pkg::SIZE_W'(PAYLOAD_BYTES));
    full_sel = 1'b0;
    found    = 1'b0;
    rx_prio  = '0;
    rx_head  = '0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (prio_r == spmq_pkg::PRIO_W'(i)) begin
        full_sel = stat[i].full;
      end
    end
    // Most urgent level that holds a message.
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (!stat[i].empty) begin
        found   = 1'b1;
        rx_prio = spmq_pkg::PRIO_W'(i);
        rx_head = heads[i];
      end
    end

    push_ok = 1'b0;
    pop_ok  = 1'b0;
    if (act_r == spmq_pkg::ACT_RECV) begin
      pop_ok = found;
      status = found ? spmq_pkg::ST_OK : spmq_pkg::ST_EMPTY;
    end else if (!prio_ok) begin
      status = spmq_pkg::ST_BAD_PRIO;
    end else if (!size_ok) begin
      status = spmq_pkg::ST_TOO_LARGE;
    end else if (full_sel) begin
      status = spmq_pkg::ST_FULL;
    end else begin
      push_ok = 1'b1;
      status  = spmq_pkg::ST_OK;
    end

    for (int i = 0; i < NUM_LEVELS; i++) begin
      ctrl[i].push = exec && push_ok && (prio_r == spmq_pkg::PRIO_W'(i));
      ctrl[i].pop  = exec && pop_ok && (rx_prio == spmq_pkg::PRIO_W'(i));
    end

    total_nxt = total_r;
    if (exec && push_ok) begin
      total_nxt = total_r + TOT_W'(1);
    end else if (exec && pop_ok) begin
      total_nxt = total_r - TOT_W'(1);
    end
    total_ext = (TOT_W + spmq_pkg::PEND_W)'(total_nxt);

    o_type    = pop_ok ? rx_head[spmq_pkg::TYPE_W-1:0] : '0;
    o_payload = pop_ok ? spmq_pkg::PAYLOAD_W'(rx_head[ENT_W-1:spmq_pkg::TYPE_W]) : '0;
    o_prio    = pop_ok ? rx_prio : '0;
    out_data_nxt = {3'b000, total_ext[spmq_pkg::PEND_W-1:0], o_prio, o_payload, o_type,
                    status};
  end

  // One level per priority, each a row of cells.
  for (genvar i = 0; i < NUM_LEVELS; i++) begin : g_level
    spmq_level #(
      .FIFO_DEPTH (FIFO_DEPTH),
      .ENT_W      (ENT_W)
    ) u_level (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl[i]),
      .new_data (new_entry),
      .head     (heads[i]),
      .count    (counts[i]),
      .stat     (stat[i])
    );
  end

  // Handshake state of the request and output registers.
  always_comb begin
    busy_nxt = busy_r;
    if (in_fire) begin
      busy_nxt = 1'b1;
    end else if (exec) begin
      busy_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      total_r     <= '0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      total_r     <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Sum of the level counts, used only to check the running total.
  always_comb begin
    cnt_sum = '0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      cnt_sum = cnt_sum + TOT_W'(counts[i]);
    end
  end

  // The running total always agrees with the levels.
  a_total_matches: assert property (@(posedge clk) disable iff (!rst_n)
    total_r == cnt_sum)
    else $error("running total differs from the sum of level counts");

  // A successful receive removes exactly one message.
  a_pop_decrements: assert property (@(posedge clk) disable iff (!rst_n)
    (exec && pop_ok) |=> (total_r == $past(total_r) - TOT_W'(1)))
    else $error("receive did not remove one message");

  // An empty status is only reported when nothing is held.
  a_empty_means_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r[2:0] == spmq_pkg::ST_EMPTY)) |-> (out_data_r[108:102] == '0))
    else $error("empty status with messages pending");

  // No level is pushed and popped by the same request.
  a_one_update: assert property (@(posedge clk) disable iff (!rst_n)
    !(push_ok && pop_ok))
    else $error("push and pop in one request");

endmodule

// ===== verif/tb_top.sv =====
module tb_top;

  localparam int LEVELS = spmq_pkg::NUM_LEVELS_DEF;
  localparam int DEPTH  = spmq_pkg::FIFO_DEPTH_DEF;
  localparam int BYTES  = spmq_pkg::PAYLOAD_BYTES_DEF;
  localparam int RANDOM_WORDS = 800;

  typedef enum int {PH_FILL, PH_DRAIN, PH_MIX} phase_kind_t;

  // One expected result word, field by field.
  typedef struct packed {
    spmq_pkg::status_t status;
    logic [31:0]       mtype;
    logic [63:0]       body;
    logic [2:0]        level;
    logic [6:0]        pending;
  } result_word_t;

  // One row of the directed table; fixed rows carry their result typed in.
  typedef struct packed {
    logic              act;
    logic [31:0]       mtype;
    logic [2:0]        prio;
    logic [63:0]       data;
    logic [3:0]        size;
    logic              fixed;
    spmq_pkg::status_t st;
    logic [6:0]        pend;
  } plan_row_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [spmq_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic                             in_tuser = 1'b0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [spmq_pkg::OUT_TDATA_W-1:0] out_tdata;

  // Shadow copy of the per-level FIFOs, head in slot 0.
  logic [31:0] shadow_type [LEVELS][DEPTH];
  logic [63:0] shadow_body [LEVELS][DEPTH];
  int          shadow_fill [LEVELS];

  result_word_t awaited_words[$];
  plan_row_t    plan[$];

  int  errors = 0;
  int  words_in = 0;
  int  words_out = 0;
  int  seen_status [5];
  int  peak_held = 0;
  bit  smooth = 1'b0;
  int  ready_hold = 0;

  strict_priority_message_queue dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Clock, period 12.
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Works out the result of one accepted word and updates the shadow FIFOs.
  function automatic result_word_t step_queues(input logic act, input logic [31:0] mtype,
                                               input logic [2:0] prio, input logic [63:0] data,
                                               input logic [3:0] size);
    result_word_t r;
    logic [63:0]  mask;
    int           lv;
    int           k;
    int           total;
    bit           done;
    r = '0;
    r.status = spmq_pkg::ST_OK;
    if (act == spmq_pkg::ACT_SEND) begin
      if (prio >= LEVELS) begin
        r.status = spmq_pkg::ST_BAD_PRIO;
      end else if (size > BYTES) begin
        r.status = spmq_pkg::ST_TOO_LARGE;
      end else if (shadow_fill[prio] >= DEPTH) begin
        r.status = spmq_pkg::ST_FULL;
      end else begin
        // Bytes at and above the size are stored as zero.
        mask = (size >= 8) ? {64{1'b1}} : ((64'd1 << (8 * size)) - 64'd1);
        shadow_type[prio][shadow_fill[prio]] = mtype;
        shadow_body[prio][shadow_fill[prio]] = data & mask;
        shadow_fill[prio] = shadow_fill[prio] + 1;
      end
    end else begin
      // Pop the head of the most urgent level that holds anything.
      r.status = spmq_pkg::ST_EMPTY;
      done = 1'b0;
      for (lv = 0; lv < LEVELS; lv++) begin
        if (!done && shadow_fill[lv] != 0) begin
          r.status = spmq_pkg::ST_OK;
          r.mtype  = shadow_type[lv][0];
          r.body   = shadow_body[lv][0];
          r.level  = lv[2:0];
          for (k = 1; k < shadow_fill[lv]; k++) begin
            shadow_type[lv][k-1] = shadow_type[lv][k];
            shadow_body[lv][k-1] = shadow_body[lv][k];
          end
          shadow_fill[lv] = shadow_fill[lv] - 1;
          done = 1'b1;
        end
      end
    end
    total = 0;
    for (lv = 0; lv < LEVELS; lv++) begin
      total = total + shadow_fill[lv];
    end
    if (total > peak_held) begin
      peak_held = total;
    end
    r.pending = total[6:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    errors++;
    $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
  endtask

  task automatic add_row(input logic act, input logic [31:0] mtype, input logic [2:0] prio,
                         input logic [63:0] data, input logic [3:0] size, input logic fixed,
                         input spmq_pkg::status_t st, input logic [6:0] pend);
    plan_row_t r;
    r.act = act;
    r.mtype = mtype;
    r.prio = prio;
    r.data = data;
    r.size = size;
    r.fixed = fixed;
    r.st = st;
    r.pend = pend;
    plan.push_back(r);
  endtask

  // Presents one word and holds it until it is taken, then files its result.
  task automatic offer_word(input logic act, input logic [31:0] mtype, input logic [2:0] prio,
                            input logic [63:0] data, input logic [3:0] size,
                            input logic fixed, input spmq_pkg::status_t st,
                            input logic [6:0] pend);
    result_word_t want;
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {1'b0, size, data, prio, mtype};
    do begin
      @(posedge clk);
    end while (!in_tready);
    want = step_queues(act, mtype, prio, data, size);
    if (fixed) begin
      want = '0;
      want.status = st;
      want.pending = pend;
    end
    awaited_words.push_back(want);
    words_in++;
  endtask

  // Sender gap: mostly none or short, now and then long.
  task automatic sender_gap();
    int n;
    int r;
    r = $urandom_range(0, 99);
    if (smooth || r < 50) begin
      n = 0;
    end else if (r < 92) begin
      n = $urandom_range(1, 3);
    end else begin
      n = $urandom_range(8, 30);
    end
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Hold the sender back until every outstanding result has come out.
  task automatic drain_wait();
    in_tvalid <= 1'b0;
    while (awaited_words.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Receiver back-pressure with the same mix of short and long stalls.
  always @(posedge clk) begin
    int r;
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (smooth || r < 60) begin
        out_tready <= 1'b1;
        ready_hold <= $urandom_range(0, 4);
      end else if (r < 95) begin
        out_tready <= 1'b0;
        ready_hold <= $urandom_range(0, 2);
      end else begin
        out_tready <= 1'b0;
        ready_hold <= $urandom_range(8, 40);
      end
    end
  end

  // Compare every result word with the oldest expectation.
  always @(posedge clk) begin
    result_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      words_out++;
      if (out_tdata[2:0] <= 3'd4) begin
        seen_status[out_tdata[2:0]]++;
      end
      if (awaited_words.size() == 0) begin
        report_mismatch("unexpected result word, status", out_tdata[2:0], 0);
      end else begin
        want = awaited_words.pop_front();
        if (out_tdata[2:0] !== want.status) begin
          report_mismatch("status", out_tdata[2:0], want.status);
        end
        if (out_tdata[34:3] !== want.mtype) begin
          report_mismatch("out_type", out_tdata[34:3], want.mtype);
        end
        if (out_tdata[98:35] !== want.body) begin
          report_mismatch("out_payload", out_tdata[98:35], want.body);
        end
        if (out_tdata[101:99] !== want.level) begin
          report_mismatch("out_priority", out_tdata[101:99], want.level);
        end
        if (out_tdata[108:102] !== want.pending) begin
          report_mismatch("pending_total", out_tdata[108:102], want.pending);
        end
      end
    end
  end

  // Generous overall limit.
  initial begin
    #5000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int          i;
    int          k;
    int          left;
    int          r;
    phase_kind_t phase;
    plan_row_t   row;
    logic        act;
    logic [2:0]  prio;
    logic [3:0]  size;

    for (k = 0; k < LEVELS; k++) begin
      shadow_fill[k] = 0;
    end
    for (k = 0; k < 5; k++) begin
      seen_status[k] = 0;
    end

    // Directed table: errors first, then one level filled to overflow.
    add_row(spmq_pkg::ACT_RECV, 32'hFFFF_FFFF, 3'd7, {64{1'b1}}, 4'd15, 1'b1,
            spmq_pkg::ST_EMPTY, 7'd0);
    add_row(spmq_pkg::ACT_SEND, 32'h0000_0001, 3'd5, 64'h1, 4'd8, 1'b1,
            spmq_pkg::ST_BAD_PRIO, 7'd0);
    add_row(spmq_pkg::ACT_SEND, 32'hFFFF_FFFF, 3'd7, {64{1'b1}}, 4'd15, 1'b1,
            spmq_pkg::ST_BAD_PRIO, 7'd0);
    add_row(spmq_pkg::ACT_SEND, 32'h0000_0002, 3'd0, 64'h2, 4'd9, 1'b1,
            spmq_pkg::ST_TOO_LARGE, 7'd0);
    add_row(spmq_pkg::ACT_SEND, 32'h0000_0003, 3'd4, 64'h3, 4'd15, 1'b1,
            spmq_pkg::ST_TOO_LARGE, 7'd0);
    for (k = 0; k < DEPTH; k++) begin
      add_row(spmq_pkg::ACT_SEND, (k == 0) ? 32'hFFFF_FFFF : (k == 1) ? 32'h0 : $urandom,
              3'd4, (k % 2 == 0) ? {64{1'b1}} : {$urandom, $urandom}, 4'((k + 8) % 9),
              1'b1, spmq_pkg::ST_OK, 7'(k + 1));
    end
    add_row(spmq_pkg::ACT_SEND, 32'h0BAD_F00D, 3'd4, 64'h5, 4'd1, 1'b1,
            spmq_pkg::ST_FULL, 7'(DEPTH));
    add_row(spmq_pkg::ACT_SEND, 32'h0, 3'd0, {64{1'b1}}, 4'd4, 1'b1,
            spmq_pkg::ST_OK, 7'(DEPTH + 1));
    // Level 0 must come out ahead of the full level, then the full level's head.
    add_row(spmq_pkg::ACT_RECV, $urandom, 3'd3, {$urandom, $urandom}, 4'd2, 1'b0,
            spmq_pkg::ST_OK, 7'd0);
    add_row(spmq_pkg::ACT_RECV, 32'h0, 3'd0, 64'h0, 4'd0, 1'b0, spmq_pkg::ST_OK, 7'd0);

    // Reset once, before the directed table runs.
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < plan.size(); i++) begin
      row = plan[i];
      offer_word(row.act, row.mtype, row.prio, row.data, row.size, row.fixed, row.st, row.pend);
      if (i == plan.size() - 1) begin
        drain_wait();
      end else begin
        sender_gap();
      end
    end

    // Random part in phases that fill, drain or mix the levels.
    left = 0;
    phase = PH_MIX;
    for (i = 0; i < RANDOM_WORDS; i++) begin
      if (left == 0) begin
        left = $urandom_range(40, 120);
        phase = phase_kind_t'($urandom_range(0, 2));
        smooth = ($urandom_range(0, 3) == 0);
      end
      r = $urandom_range(0, 99);
      case (phase)
        PH_FILL: begin
          act = (r < 85) ? spmq_pkg::ACT_SEND : spmq_pkg::ACT_RECV;
        end
        PH_DRAIN: begin
          act = (r < 15) ? spmq_pkg::ACT_SEND : spmq_pkg::ACT_RECV;
        end
        default: begin
          act = (r < 50) ? spmq_pkg::ACT_SEND : spmq_pkg::ACT_RECV;
        end
      endcase
      // Mostly legal levels and sizes, with some out of range.
      prio = ($urandom_range(0, 99) < 85) ? 3'($urandom_range(0, LEVELS - 1))
                                           : 3'($urandom_range(LEVELS, 7));
      size = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, BYTES))
                                           : 4'($urandom_range(BYTES + 1, 15));
      offer_word(act, $urandom, prio, {$urandom, $urandom}, size, 1'b0, spmq_pkg::ST_OK,
                 7'd0);
      left--;
      if (left == 0 && $urandom_range(0, 2) == 0) begin
        drain_wait();
      end else if (i != RANDOM_WORDS - 1) begin
        sender_gap();
      end
    end
    in_tvalid <= 1'b0;
    smooth = 1'b0;

    // Let the outstanding results drain, then watch for stray words.
    while (awaited_words.size() != 0) begin
      @(posedge clk);
    end
    repeat (10) @(posedge clk);

    $display("Run covered %0d words in and %0d results out, peak occupancy %0d of %0d.",
             words_in, words_out, peak_held, LEVELS * DEPTH);
    $display("Statuses seen: ok %0d, bad priority %0d, too large %0d, full %0d, empty %0d.",
             seen_status[0], seen_status[1], seen_status[2], seen_status[3], seen_status[4]);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
